### src/rsm_pkg.sv
`timescale 1ns / 1ps
package rsm_pkg;

  localparam int unsigned SecW   = 24;
  localparam int unsigned AckW   = 16;
  localparam int unsigned RetryW = 4;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned ActW   = 3;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [SecW-1:0]   LifetimeReset = SecW'(86400);
  localparam logic [SecW-1:0]   MarginReset   = SecW'(60);
  localparam logic [AckW-1:0]   AckReset      = AckW'(30);
  localparam logic [RetryW-1:0] RetxReset     = RetryW'(3);

  localparam logic [CodeW-1:0] CodeCreated  = 8'h41;
  localparam logic [2:0]       ClassSuccess = 3'd2;
  localparam logic [SecW-1:0]  ElapsedMax   = {SecW{1'b1}};

  // register index, taken from paddr[3:2]
  localparam logic [1:0] RegLifetime = 2'd0;
  localparam logic [1:0] RegMargin   = 2'd1;
  localparam logic [1:0] RegAck      = 2'd2;
  localparam logic [1:0] RegRetx     = 2'd3;

  localparam logic [ActW-1:0] ActRegister   = 3'd0;
  localparam logic [ActW-1:0] ActUpdate     = 3'd1;
  localparam logic [ActW-1:0] ActDeregister = 3'd2;
  localparam logic [ActW-1:0] ActResponse   = 3'd3;
  localparam logic [ActW-1:0] ActTick       = 3'd4;

  typedef enum logic [2:0] {
    PhUnreg      = 3'd0,
    PhAwaitReg   = 3'd1,
    PhRegistered = 3'd2,
    PhAwaitUpd   = 3'd3,
    PhAwaitDereg = 3'd4,
    PhFailed     = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    RecNone       = 2'd0,
    RecRetransmit = 2'd1,
    RecReregister = 2'd2
  } recovery_e;

  // settings the core needs, due point already worked out
  typedef struct packed {
    logic [SecW-1:0]   due_at;
    logic [AckW-1:0]   ack_timeout;
    logic [RetryW-1:0] max_retx;
  } cfg_t;

endpackage

### src/rsm_cfg.sv
`timescale 1ns / 1ps
module rsm_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rsm_pkg::AddrW-1:0]    paddr,
  input  logic [rsm_pkg::DataW-1:0]    pwdata,
  output logic [rsm_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output rsm_pkg::cfg_t                cfg_o
);

  logic [rsm_pkg::SecW-1:0]   lifetime_q;
  logic [rsm_pkg::SecW-1:0]   margin_q;
  logic [rsm_pkg::AckW-1:0]   ack_q;
  logic [rsm_pkg::RetryW-1:0] retx_q;
  logic [rsm_pkg::SecW-1:0]   due_at;
  logic                       wr_en;
  logic [1:0]                 idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= rsm_pkg::LifetimeReset;
      margin_q   <= rsm_pkg::MarginReset;
      ack_q      <= rsm_pkg::AckReset;
      retx_q     <= rsm_pkg::RetxReset;
    end else if (wr_en) begin
      unique case (idx)
        rsm_pkg::RegLifetime: lifetime_q <= pwdata[rsm_pkg::SecW-1:0];
        rsm_pkg::RegMargin:   margin_q   <= pwdata[rsm_pkg::SecW-1:0];
        rsm_pkg::RegAck:      ack_q      <= pwdata[rsm_pkg::AckW-1:0];
        rsm_pkg::RegRetx:     retx_q     <= pwdata[rsm_pkg::RetryW-1:0];
        default: ;
      endcase
    end
  end

  // update point: lifetime minus margin, floored at zero
  always_comb begin
    if (margin_q >= lifetime_q) begin
      due_at = '0;
    end else begin
      due_at = lifetime_q - margin_q;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      rsm_pkg::RegLifetime: prdata = rsm_pkg::DataW'(lifetime_q);
      rsm_pkg::RegMargin:   prdata = rsm_pkg::DataW'(margin_q);
      rsm_pkg::RegAck:      prdata = rsm_pkg::DataW'(ack_q);
      rsm_pkg::RegRetx:     prdata = rsm_pkg::DataW'(retx_q);
      default:              prdata = '0;
    endcase
  end

  assign cfg_o.due_at      = due_at;
  assign cfg_o.ack_timeout = ack_q;
  assign cfg_o.max_retx    = retx_q;

endmodule

### src/rsm_core.sv
`timescale 1ns / 1ps
module rsm_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rsm_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rsm_pkg::ActW-1:0]    action_i,
  input  logic [rsm_pkg::CodeW-1:0]   response_code_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  reg_state_o,
  output logic [1:0]                  recovery_o,
  output logic                        update_due_o,
  output logic                        location_valid_o
);

  // input stage
  logic                      in_v_q;
  logic [rsm_pkg::ActW-1:0]  act_q;
  logic [rsm_pkg::CodeW-1:0] code_q;

  // protocol state
  rsm_pkg::phase_e            phase_q, phase_d;
  logic [rsm_pkg::SecW-1:0]   elapsed_q, elapsed_d;
  logic [rsm_pkg::RetryW-1:0] retry_q, retry_d;
  logic                       loc_q, loc_d;

  // result stage
  logic                out_v_q;
  rsm_pkg::phase_e     res_phase_q;
  rsm_pkg::recovery_e  res_rec_q, rec_d;
  logic                res_due_q, due_d;
  logic                res_loc_q;

  logic                     adv;
  logic                     fire;
  logic                     awaiting;
  logic                     ok;
  logic [rsm_pkg::SecW-1:0] elapsed_inc;

  assign adv        = !out_v_q || out_ready_i;
  assign fire       = in_v_q && adv;
  assign in_ready_o = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      act_q  <= action_i;
      code_q <= response_code_i;
    end
  end

  assign awaiting = (phase_q == rsm_pkg::PhAwaitReg) || (phase_q == rsm_pkg::PhAwaitUpd) ||
                    (phase_q == rsm_pkg::PhAwaitDereg);
  assign ok       = (code_q[7:5] == rsm_pkg::ClassSuccess);
  assign elapsed_inc = (elapsed_q == rsm_pkg::ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;

  // next state
  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    retry_d   = retry_q;
    loc_d     = loc_q;
    rec_d     = rsm_pkg::RecNone;
    unique case (act_q)
      rsm_pkg::ActRegister: begin
        phase_d   = rsm_pkg::PhAwaitReg;
        elapsed_d = '0;
      end
      rsm_pkg::ActUpdate: begin
        phase_d   = rsm_pkg::PhAwaitUpd;
        elapsed_d = '0;
      end
      rsm_pkg::ActDeregister: begin
        phase_d   = rsm_pkg::PhAwaitDereg;
        elapsed_d = '0;
      end
      rsm_pkg::ActResponse: begin
        if (awaiting) begin
          retry_d = '0;
          phase_d = rsm_pkg::PhFailed;
          priority if (phase_q == rsm_pkg::PhAwaitReg) begin
            if (ok && code_q == rsm_pkg::CodeCreated) begin
              loc_d     = 1'b1;
              phase_d   = rsm_pkg::PhRegistered;
              elapsed_d = '0;
            end
          end else if (phase_q == rsm_pkg::PhAwaitUpd) begin
            if (ok) begin
              phase_d   = rsm_pkg::PhRegistered;
              elapsed_d = '0;
            end
          end else begin
            if (ok) begin
              phase_d = rsm_pkg::PhUnreg;
              loc_d   = 1'b0;
            end
          end
        end
      end
      rsm_pkg::ActTick: begin
        elapsed_d = elapsed_inc;
        if (awaiting &&
            elapsed_inc >= rsm_pkg::SecW'(cfg_i.ack_timeout)) begin
          if (phase_q == rsm_pkg::PhAwaitUpd && retry_q < cfg_i.max_retx) begin
            retry_d = retry_q + 1'b1;
            phase_d = rsm_pkg::PhRegistered;
            rec_d   = rsm_pkg::RecRetransmit;
          end else begin
            retry_d = '0;
            phase_d = rsm_pkg::PhUnreg;
            loc_d   = 1'b0;
            rec_d   = rsm_pkg::RecReregister;
          end
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    due_d = (phase_d == rsm_pkg::PhRegistered) && (elapsed_d >= cfg_i.due_at);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rsm_pkg::PhUnreg;
      elapsed_q <= '0;
      retry_q   <= '0;
      loc_q     <= 1'b0;
    end else if (fire) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      retry_q   <= retry_d;
      loc_q     <= loc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_phase_q <= phase_d;
      res_rec_q   <= rec_d;
      res_due_q   <= due_d;
      res_loc_q   <= loc_d;
    end
  end

  assign out_valid_o      = out_v_q;
  assign reg_state_o      = res_phase_q;
  assign recovery_o       = res_rec_q;
  assign update_due_o     = res_due_q;
  assign location_valid_o = res_loc_q;

`ifndef SYNTHESIS
  a_retx_registered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && res_rec_q == rsm_pkg::RecRetransmit |-> res_phase_q == rsm_pkg::PhRegistered)
    else $error("retransmit reported outside registered");

  a_rereg_unreg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && res_rec_q == rsm_pkg::RecReregister |-> res_phase_q == rsm_pkg::PhUnreg)
    else $error("re-register reported outside unregistered");

  a_due_registered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && res_due_q |-> res_phase_q == rsm_pkg::PhRegistered)
    else $error("update due while not registered");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(phase_q) && $stable(elapsed_q) && $stable(retry_q))
    else $error("state moved without a beat");

  a_ready_only_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_v_q && out_v_q && !out_ready_i)
    else $error("input stalled with room downstream");
`endif

endmodule

### src/registration_state_machine_top.sv
`timescale 1ns / 1ps
// Registration state machine for a device-management client.
// Input channel (in_valid_i / in_ready_o) carries one event per beat:
//   action_i 0 register sent, 1 update sent, 2 deregister sent, 3 response
//   (response_code_i holds the code byte), 4 one-second tick.
// Output channel (out_valid_o / out_ready_i) returns one beat per event with
//   the state after it, tick recovery, update-due and location flags.
// An event passes the input register, then the state update writes the
//   result register. Throughput is one event per cycle while the receiver
//   takes results, set by the single pass through the state logic.
// When the receiver stalls, the result register holds and the input
//   register takes one more event; in_ready_o drops only while both are full.
// Reset clears the state to unregistered with no location and loads the
//   default settings (lifetime 86400, margin 60, ack timeout 30, 3 retries).
// Settings are written on the APB port at 4*index; the user must do so while no event is pending (unenforced).
module registration_state_machine_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsm_pkg::AddrW-1:0]   paddr,
  input  logic [rsm_pkg::DataW-1:0]   pwdata,
  output logic [rsm_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rsm_pkg::ActW-1:0]    action_i,
  input  logic [rsm_pkg::CodeW-1:0]   response_code_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  reg_state_o,
  output logic [1:0]                  recovery_o,
  output logic                        update_due_o,
  output logic                        location_valid_o
);

  rsm_pkg::cfg_t cfg;

  rsm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rsm_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .response_code_i  (response_code_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .reg_state_o      (reg_state_o),
    .recovery_o       (recovery_o),
    .update_due_o     (update_due_o),
    .location_valid_o (location_valid_o)
  );

endmodule

### tb/sv/tb_registration_state_machine_top.sv
`timescale 1ns / 1ps
module tb_registration_state_machine_top;

  // action codes the block does not define; they must leave the state alone
  localparam logic [rsm_pkg::ActW-1:0] ActSpareLo = 3'd5;
  localparam logic [rsm_pkg::ActW-1:0] ActSpareHi = 3'd7;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned RandomPhases = 5;
  localparam int unsigned PhaseEvents  = 400;

  typedef struct packed {
    rsm_pkg::phase_e    st;
    rsm_pkg::recovery_e rec;
    logic               due;
    logic               loc;
  } status_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [rsm_pkg::AddrW-1:0]   paddr;
  logic [rsm_pkg::DataW-1:0]   pwdata;
  logic [rsm_pkg::DataW-1:0]   prdata;
  logic                        pready;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [rsm_pkg::ActW-1:0]    action_i;
  logic [rsm_pkg::CodeW-1:0]   response_code_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [2:0]                  reg_state_o;
  logic [1:0]                  recovery_o;
  logic                        update_due_o;
  logic                        location_valid_o;

  registration_state_machine_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .response_code_i  (response_code_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .reg_state_o      (reg_state_o),
    .recovery_o       (recovery_o),
    .update_due_o     (update_due_o),
    .location_valid_o (location_valid_o)
  );

  // client model state and its copy of the settings
  rsm_pkg::phase_e             cl_phase;
  logic [rsm_pkg::SecW-1:0]    cl_elapsed;
  logic [rsm_pkg::RetryW-1:0]  cl_retry;
  logic                        cl_loc;
  logic [rsm_pkg::SecW-1:0]    cl_life;
  logic [rsm_pkg::SecW-1:0]    cl_margin;
  logic [rsm_pkg::AckW-1:0]    cl_ack;
  logic [rsm_pkg::RetryW-1:0]  cl_max_retx;

  status_t     pending_status[$];
  int unsigned errors;
  int unsigned events_sent;
  int unsigned events_accepted;
  int unsigned results_checked;
  int unsigned settings_writes;
  int unsigned idle_cycles;

  bit          tx_gaps;
  int unsigned tx_burst_left;
  int unsigned rx_cycle;
  int unsigned rx_mode;
  int unsigned rx_hold;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
             results_checked);
    errors++;
  endtask

  function automatic logic awaiting();
    return cl_phase == rsm_pkg::PhAwaitReg || cl_phase == rsm_pkg::PhAwaitUpd ||
           cl_phase == rsm_pkg::PhAwaitDereg;
  endfunction

  function automatic status_t advance_client(input logic [rsm_pkg::ActW-1:0] act,
                                             input logic [rsm_pkg::CodeW-1:0] code);
    status_t                  s;
    logic                     ok;
    logic [rsm_pkg::SecW-1:0] due_at;
    s.rec = rsm_pkg::RecNone;
    ok = code[7:5] == rsm_pkg::ClassSuccess;
    case (act)
      rsm_pkg::ActRegister: begin
        cl_phase   = rsm_pkg::PhAwaitReg;
        cl_elapsed = '0;
      end
      rsm_pkg::ActUpdate: begin
        cl_phase   = rsm_pkg::PhAwaitUpd;
        cl_elapsed = '0;
      end
      rsm_pkg::ActDeregister: begin
        cl_phase   = rsm_pkg::PhAwaitDereg;
        cl_elapsed = '0;
      end
      rsm_pkg::ActResponse: begin
        if (awaiting()) begin
          cl_retry = '0;
          if (cl_phase == rsm_pkg::PhAwaitReg) begin
            if (ok && code == rsm_pkg::CodeCreated) begin
              cl_loc     = 1'b1;
              cl_phase   = rsm_pkg::PhRegistered;
              cl_elapsed = '0;
            end else begin
              cl_phase = rsm_pkg::PhFailed;
            end
          end else if (cl_phase == rsm_pkg::PhAwaitUpd) begin
            if (ok) begin
              cl_phase   = rsm_pkg::PhRegistered;
              cl_elapsed = '0;
            end else begin
              cl_phase = rsm_pkg::PhFailed;
            end
          end else begin
            if (ok) begin
              cl_phase = rsm_pkg::PhUnreg;
              cl_loc   = 1'b0;
            end else begin
              cl_phase = rsm_pkg::PhFailed;
            end
          end
        end
      end
      rsm_pkg::ActTick: begin
        if (cl_elapsed != rsm_pkg::ElapsedMax) cl_elapsed = cl_elapsed + 1'b1;
        if (awaiting() && cl_elapsed >= rsm_pkg::SecW'(cl_ack)) begin
          if (cl_phase == rsm_pkg::PhAwaitUpd && cl_retry < cl_max_retx) begin
            cl_retry = cl_retry + 1'b1;
            cl_phase = rsm_pkg::PhRegistered;
            s.rec    = rsm_pkg::RecRetransmit;
          end else begin
            cl_retry = '0;
            cl_phase = rsm_pkg::PhUnreg;
            cl_loc   = 1'b0;
            s.rec    = rsm_pkg::RecReregister;
          end
        end
      end
      default: ;
    endcase
    due_at = (cl_margin >= cl_life) ? '0 : cl_life - cl_margin;
    s.st  = cl_phase;
    s.due = (cl_phase == rsm_pkg::PhRegistered) && (cl_elapsed >= due_at);
    s.loc = cl_loc;
    return s;
  endfunction

  // result check first, then prediction for the beat taken on the same edge
  always @(posedge clk_i) begin
    status_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_status.size() == 0) begin
          note_mismatch("result with nothing pending", reg_state_o, 0);
        end else begin
          want = pending_status.pop_front();
          if (reg_state_o != want.st)
            note_mismatch("reg_state", reg_state_o, want.st);
          if (recovery_o != want.rec)
            note_mismatch("recovery", recovery_o, want.rec);
          if (update_due_o != want.due)
            note_mismatch("update_due", update_due_o, want.due);
          if (location_valid_o != want.loc)
            note_mismatch("location_valid", location_valid_o, want.loc);
        end
        results_checked++;
      end
      if (in_valid_i && in_ready_o) begin
        pending_status = {pending_status, advance_client(action_i, response_code_i)};
        events_accepted++;
      end
    end
  end

  // receiver: the stall pattern is redrawn at random from four modes
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 99) < 60;
      2: out_ready_i <= (rx_cycle % 5) < 3;
      default: begin
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(1, 25);
          out_ready_i <= ~out_ready_i;
        end else begin
          rx_hold--;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog: %0d cycles without a beat, %0d results pending",
                 idle_cycles, pending_status.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_event(input logic [rsm_pkg::ActW-1:0] act,
                            input logic [rsm_pkg::CodeW-1:0] code);
    int unsigned gap;
    in_valid_i      <= 1'b1;
    action_i        <= act;
    response_code_i <= code;
    do @(posedge clk_i); while (!in_ready_o);
    events_sent++;
    gap = 0;
    if (tx_gaps) begin
      if (tx_burst_left == 0) begin
        tx_burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 5);
      end else begin
        tx_burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [1:0] idx,
                                input logic [rsm_pkg::DataW-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata != want) note_mismatch("register readback", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [rsm_pkg::DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rsm_pkg::RegLifetime: cl_life     = value[rsm_pkg::SecW-1:0];
      rsm_pkg::RegMargin:   cl_margin   = value[rsm_pkg::SecW-1:0];
      rsm_pkg::RegAck:      cl_ack      = value[rsm_pkg::AckW-1:0];
      rsm_pkg::RegRetx:     cl_max_retx = value[rsm_pkg::RetryW-1:0];
      default: ;
    endcase
    settings_writes++;
    @(posedge clk_i);
    apb_read_check(idx, value);
  endtask

  task automatic write_settings(input logic [rsm_pkg::SecW-1:0] life,
                                input logic [rsm_pkg::SecW-1:0] margin,
                                input logic [rsm_pkg::AckW-1:0] ack,
                                input logic [rsm_pkg::RetryW-1:0] retx);
    apb_write(rsm_pkg::RegLifetime, rsm_pkg::DataW'(life));
    apb_write(rsm_pkg::RegMargin, rsm_pkg::DataW'(margin));
    apb_write(rsm_pkg::RegAck, rsm_pkg::DataW'(ack));
    apb_write(rsm_pkg::RegRetx, rsm_pkg::DataW'(retx));
  endtask

  task automatic test_reset_defaults();
    apb_read_check(rsm_pkg::RegLifetime, rsm_pkg::DataW'(rsm_pkg::LifetimeReset));
    apb_read_check(rsm_pkg::RegMargin, rsm_pkg::DataW'(rsm_pkg::MarginReset));
    apb_read_check(rsm_pkg::RegAck, rsm_pkg::DataW'(rsm_pkg::AckReset));
    apb_read_check(rsm_pkg::RegRetx, rsm_pkg::DataW'(rsm_pkg::RetxReset));
    // tick and response while unregistered, then the undefined actions
    send_event(rsm_pkg::ActTick, 8'h00);
    send_event(rsm_pkg::ActResponse, rsm_pkg::CodeCreated);
    for (int a = ActSpareLo; a <= ActSpareHi; a++) send_event(rsm_pkg::ActW'(a), 8'hFF);
    drain();
  endtask

  task automatic test_directed_flows();
    write_settings(24'd3, 24'd1, 16'd2, 4'd1);
    send_event(rsm_pkg::ActRegister, 8'h00);
    send_event(rsm_pkg::ActResponse, rsm_pkg::CodeCreated);
    send_event(rsm_pkg::ActTick, 8'h00);
    send_event(rsm_pkg::ActTick, 8'h00);          // reaches the update-due point
    send_event(rsm_pkg::ActUpdate, 8'h00);
    send_event(rsm_pkg::ActTick, 8'h00);
    send_event(rsm_pkg::ActTick, 8'h00);          // ack timeout, retransmit
    send_event(rsm_pkg::ActUpdate, 8'h00);
    send_event(rsm_pkg::ActTick, 8'h00);
    send_event(rsm_pkg::ActTick, 8'h00);          // retries used up, re-register
    send_event(rsm_pkg::ActRegister, 8'h00);
    send_event(rsm_pkg::ActResponse, 8'h44);      // success class but not created
    send_event(rsm_pkg::ActUpdate, 8'h00);
    send_event(rsm_pkg::ActResponse, 8'h60);
    send_event(rsm_pkg::ActRegister, 8'h00);
    send_event(rsm_pkg::ActResponse, rsm_pkg::CodeCreated);
    send_event(rsm_pkg::ActUpdate, 8'h00);
    send_event(rsm_pkg::ActResponse, 8'h5F);
    send_event(rsm_pkg::ActDeregister, 8'h00);
    send_event(rsm_pkg::ActResponse, 8'hFF);
    send_event(rsm_pkg::ActDeregister, 8'h00);
    send_event(rsm_pkg::ActResponse, 8'h40);
    send_event(rsm_pkg::ActRegister, 8'h00);
    send_event(rsm_pkg::ActTick, 8'h00);
    send_event(rsm_pkg::ActTick, 8'h00);          // register never acknowledged
    drain();
  endtask

  task automatic test_setting_extremes();
    // margin above lifetime: due point saturates at zero
    write_settings(24'd1, rsm_pkg::ElapsedMax, 16'd1, 4'd0);
    send_event(rsm_pkg::ActRegister, 8'h00);
    send_event(rsm_pkg::ActResponse, rsm_pkg::CodeCreated);
    send_event(rsm_pkg::ActUpdate, 8'h00);
    send_event(rsm_pkg::ActTick, 8'h00);
    drain();
    write_settings(rsm_pkg::ElapsedMax, 24'd0, 16'hFFFF, 4'd15);
    send_event(rsm_pkg::ActRegister, 8'h00);
    send_event(rsm_pkg::ActResponse, rsm_pkg::CodeCreated);
    repeat (4) send_event(rsm_pkg::ActTick, 8'h00);
    send_event(rsm_pkg::ActUpdate, 8'h00);
    repeat (4) send_event(rsm_pkg::ActTick, 8'h00);
    drain();
    // every retransmit in turn, then the drop to unregistered
    apb_write(rsm_pkg::RegAck, rsm_pkg::DataW'(16'd1));
    send_event(rsm_pkg::ActRegister, 8'h00);
    send_event(rsm_pkg::ActResponse, rsm_pkg::CodeCreated);
    repeat (16) begin
      send_event(rsm_pkg::ActUpdate, 8'h00);
      send_event(rsm_pkg::ActTick, 8'h00);
    end
    drain();
  endtask

  function automatic logic [rsm_pkg::CodeW-1:0] pick_code();
    case ($urandom_range(0, 3))
      0, 1:    return rsm_pkg::CodeCreated;
      2:       return {rsm_pkg::ClassSuccess, 5'($urandom)};
      default: return rsm_pkg::CodeW'($urandom);
    endcase
  endfunction

  task automatic test_random_traffic();
    int unsigned target;
    int unsigned tick_cap;
    for (int k = 0; k < RandomPhases; k++) begin
      if (k == RandomPhases - 1)
        write_settings(rsm_pkg::SecW'($urandom_range(1, 24'hFFFFFF)),
                       rsm_pkg::SecW'($urandom),
                       rsm_pkg::AckW'($urandom_range(1, 16'hFFFF)),
                       rsm_pkg::RetryW'($urandom));
      else
        write_settings(rsm_pkg::SecW'($urandom_range(1, 20)),
                       rsm_pkg::SecW'($urandom_range(0, 25)),
                       rsm_pkg::AckW'($urandom_range(1, 4)),
                       rsm_pkg::RetryW'($urandom_range(0, 3)));
      tx_gaps = (k != 1);
      tick_cap = (cl_ack < 10) ? cl_ack + 1 : 10;
      target = events_sent + PhaseEvents;
      while (events_sent < target) begin
        if ($urandom_range(0, 9) < 8) begin
          case ($urandom_range(0, 2))
            0:       send_event(rsm_pkg::ActRegister, rsm_pkg::CodeW'($urandom));
            1:       send_event(rsm_pkg::ActUpdate, rsm_pkg::CodeW'($urandom));
            default: send_event(rsm_pkg::ActDeregister, rsm_pkg::CodeW'($urandom));
          endcase
          if ($urandom_range(0, 9) < 6) begin
            send_event(rsm_pkg::ActResponse, pick_code());
            // idle ticks while registered walk toward the due point
            repeat ($urandom_range(0, 12))
              send_event(rsm_pkg::ActTick, rsm_pkg::CodeW'($urandom));
          end else begin
            repeat ($urandom_range(1, tick_cap))
              send_event(rsm_pkg::ActTick, rsm_pkg::CodeW'($urandom));
          end
        end else begin
          send_event(rsm_pkg::ActW'($urandom), rsm_pkg::CodeW'($urandom));
        end
      end
      drain();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    action_i        = '0;
    response_code_i = '0;
    out_ready_i     = 1'b0;
    cl_phase        = rsm_pkg::PhUnreg;
    cl_elapsed      = '0;
    cl_retry        = '0;
    cl_loc          = 1'b0;
    cl_life         = rsm_pkg::LifetimeReset;
    cl_margin       = rsm_pkg::MarginReset;
    cl_ack          = rsm_pkg::AckReset;
    cl_max_retx     = rsm_pkg::RetxReset;
    tx_gaps         = 1'b1;
    rx_mode         = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_flows();
    test_setting_extremes();
    test_random_traffic();

    $display("Ran %0d events (%0d results checked) across %0d register writes",
             events_accepted, results_checked, settings_writes);
    $display("Covered directed flows, setting extremes and %0d random phases", RandomPhases);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, pending_status.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
src/rsm_pkg.sv
src/rsm_cfg.sv
src/rsm_core.sv
src/registration_state_machine_top.sv
tb/sv/tb_registration_state_machine_top.sv
